// ===== sv/pmpc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmpc_pkg
// Shared types, codes and color helpers of the pixel mix and palette unit.
// ----------------------------------------------------------------------------
package pmpc_pkg;

    // Palette RAM: 64 bytes seen as 32 little-endian 16-bit color words.
    localparam int PAL_BYTES   = 64;
    localparam int PAL_WORDS   = PAL_BYTES / 2;
    localparam int PAL_BYTE_AW = $clog2(PAL_BYTES);
    localparam int PAL_WORD_AW = $clog2(PAL_WORDS);

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Item kinds carried in s_tuser.
    localparam logic [1:0] ACT_MIX    = 2'd0;
    localparam logic [1:0] ACT_WR_BG  = 2'd1;
    localparam logic [1:0] ACT_WR_OBJ = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BG_ENABLE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BG_MAP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OBJ_MAP0   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OBJ_MAP1   = 3'd4;

    typedef struct packed {
        logic [1:0] bg_color_id;
        logic [2:0] bg_palette_num;
        logic       bg_priority;
        logic       sprite_present;
        logic [1:0] sprite_color_id;
        logic [2:0] sprite_palette_num;
        logic       sprite_behind_bg;
    } pix_t;

    typedef struct packed {
        logic       color_mode;
        logic       bg_enable;
        logic [7:0] bg_shade_map;
        logic [7:0] obj_shade_map0;
        logic [7:0] obj_shade_map1;
    } cfg_t;

    typedef struct packed {
        logic                   sprite_wins;
        logic [23:0]            mono_rgb;
        logic [PAL_WORD_AW-1:0] bg_addr;
        logic [PAL_WORD_AW-1:0] obj_addr;
    } sel_t;

    function automatic logic [23:0] shade_rgb(input logic [1:0] idx);
        logic [23:0] rgb;
        unique case (idx)
            2'd0: rgb = 24'he0f8d0;
            2'd1: rgb = 24'h88c070;
            2'd2: rgb = 24'h346856;
            2'd3: rgb = 24'h081820;
        endcase
        return rgb;
    endfunction

    // RGB555 to RGB888 by replicating the top bits of each channel.
    function automatic logic [23:0] rgb555_to_888(input logic [15:0] w);
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
        r = w[4:0];
        g = w[9:5];
        b = w[14:10];
        return {r, r[4:2], g, g[4:2], b, b[4:2]};
    endfunction

endpackage

// ===== sv/pmpc_pal_ram.sv =====
// ----------------------------------------------------------------------------
// pmpc_pal_ram
// Palette RAM: byte writes, registered 16-bit word reads.
// Per-byte valid bits make bytes that were never written read as zero.
// ----------------------------------------------------------------------------
module pmpc_pal_ram (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [pmpc_pkg::PAL_BYTE_AW-1:0] wr_addr,
    input  logic [7:0]                       wr_data,
    input  logic                             rd_en,
    input  logic [pmpc_pkg::PAL_WORD_AW-1:0] rd_addr,
    output logic [15:0]                      rd_data
);

    logic [1:0][7:0] mem [pmpc_pkg::PAL_WORDS];
    logic [1:0]      lane_valid_reg [pmpc_pkg::PAL_WORDS];
    logic [1:0][7:0] rd_word_reg;
    logic [1:0]      rd_valid_reg;

    logic [pmpc_pkg::PAL_WORD_AW-1:0] wr_word;
    logic                             wr_lane;

    assign wr_word = wr_addr[pmpc_pkg::PAL_BYTE_AW-1:1];
    assign wr_lane = wr_addr[0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_word][wr_lane] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pmpc_pkg::PAL_WORDS; i++)
            begin
                lane_valid_reg[i] <= 2'b00;
            end
            rd_valid_reg <= 2'b00;
        end
        else
        begin
            if (wr_en)
            begin
                lane_valid_reg[wr_word][wr_lane] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= lane_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = {rd_valid_reg[1] ? rd_word_reg[1] : 8'h00,
                      rd_valid_reg[0] ? rd_word_reg[0] : 8'h00};

endmodule

// ===== sv/pmpc_select.sv =====
// ----------------------------------------------------------------------------
// pmpc_select
// Priority decision between background and sprite pixel, monochrome shade
// lookup, and palette RAM word addresses for color mode.
// ----------------------------------------------------------------------------
module pmpc_select (
    input  pmpc_pkg::pix_t pix,
    input  pmpc_pkg::cfg_t cfg,
    output pmpc_pkg::sel_t sel
);

    logic       spr_visible;
    logic       bg_nonzero;
    logic       mono_wins;
    logic       color_wins;
    logic       wins;
    logic [7:0] obj_map;
    logic [1:0] obj_shade;
    logic [1:0] bg_shade;

    always_comb
    begin
        spr_visible = pix.sprite_present && (pix.sprite_color_id != 2'd0);
        bg_nonzero  = (pix.bg_color_id != 2'd0);

        // A disabled background never hides a sprite; in monochrome mode it shows shade 0.
        mono_wins  = spr_visible && !(pix.sprite_behind_bg && cfg.bg_enable && bg_nonzero);
        color_wins = spr_visible && (!bg_nonzero || !cfg.bg_enable
                                     || (!pix.sprite_behind_bg && !pix.bg_priority));
        wins       = cfg.color_mode ? color_wins : mono_wins;

        obj_map   = pix.sprite_palette_num[0] ? cfg.obj_shade_map1 : cfg.obj_shade_map0;
        obj_shade = obj_map[{pix.sprite_color_id, 1'b0} +: 2];
        bg_shade  = cfg.bg_enable ? cfg.bg_shade_map[{pix.bg_color_id, 1'b0} +: 2] : 2'd0;

        sel.sprite_wins = wins;
        sel.mono_rgb    = pmpc_pkg::shade_rgb(wins ? obj_shade : bg_shade);
        sel.bg_addr     = {pix.bg_palette_num, pix.bg_color_id};
        sel.obj_addr    = {pix.sprite_palette_num, pix.sprite_color_id};
    end

endmodule

// ===== sv/pixel_mix_and_palette_color_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_mix_and_palette_color_unit
// A mix item's palette words are read at its accept edge; the output register
// takes the result once that stage may advance (two register stages: palette
// read, then output). Throughput: one item per cycle while the output is not
// stalled; a palette write at its accept edge is seen by the next mix item.
// Reset clears all configuration registers, the pipeline and the palette
// valid bits, so the palette RAM reads as zero right after reset.
// ----------------------------------------------------------------------------
module pixel_mix_and_palette_color_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata from bit 0: bg_color_id[1:0], bg_palette_num[4:2], bg_priority[5],
    // sprite_present[6], sprite_color_id[8:7], sprite_palette_num[11:9],
    // sprite_behind_bg[12], palette_index[18:13], palette_data[26:19], zero fill
    input  logic [pmpc_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic [1:0]                           s_tuser,   // action[1:0]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    output logic [pmpc_pkg::OUT_TDATA_W-1:0]     m_tdata,   // rgb_color[23:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_wr_en,
    input  logic [pmpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pmpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pmpc_pkg::cfg_t cfg_reg;
    pmpc_pkg::pix_t pix;
    pmpc_pkg::sel_t sel;

    logic [pmpc_pkg::PAL_BYTE_AW-1:0] pal_index;
    logic [7:0]                       pal_data;
    logic                             accept;
    logic                             mix_go;
    logic [15:0]                      bg_word;
    logic [15:0]                      obj_word;

    logic        s1_valid_reg;
    logic        s1_wins_reg;
    logic        s1_mode_reg;
    logic [23:0] s1_mono_rgb_reg;
    logic        s1_advance;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [23:0] out_rgb_reg;
    logic [23:0] out_rgb_next;

    assign pix.bg_color_id        = s_tdata[1:0];
    assign pix.bg_palette_num     = s_tdata[4:2];
    assign pix.bg_priority        = s_tdata[5];
    assign pix.sprite_present     = s_tdata[6];
    assign pix.sprite_color_id    = s_tdata[8:7];
    assign pix.sprite_palette_num = s_tdata[11:9];
    assign pix.sprite_behind_bg   = s_tdata[12];
    assign pal_index              = s_tdata[18:13];
    assign pal_data               = s_tdata[26:19];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                pmpc_pkg::CFG_COLOR_MODE: cfg_reg.color_mode     <= cfg_data[0];
                pmpc_pkg::CFG_BG_ENABLE:  cfg_reg.bg_enable      <= cfg_data[0];
                pmpc_pkg::CFG_BG_MAP:     cfg_reg.bg_shade_map   <= cfg_data;
                pmpc_pkg::CFG_OBJ_MAP0:   cfg_reg.obj_shade_map0 <= cfg_data;
                pmpc_pkg::CFG_OBJ_MAP1:   cfg_reg.obj_shade_map1 <= cfg_data;
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    pmpc_select u_select (
        .pix (pix),
        .cfg (cfg_reg),
        .sel (sel)
    );

    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign accept     = s_tvalid && s_tready;
    assign mix_go     = accept && (s_tuser == pmpc_pkg::ACT_MIX);

    // Both RAMs are read for every mix item; the winner is picked afterwards.
    pmpc_pal_ram u_bg_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && (s_tuser == pmpc_pkg::ACT_WR_BG)),
        .wr_addr (pal_index),
        .wr_data (pal_data),
        .rd_en   (mix_go),
        .rd_addr (sel.bg_addr),
        .rd_data (bg_word)
    );

    pmpc_pal_ram u_obj_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && (s_tuser == pmpc_pkg::ACT_WR_OBJ)),
        .wr_addr (pal_index),
        .wr_data (pal_data),
        .rd_en   (mix_go),
        .rd_addr (sel.obj_addr),
        .rd_data (obj_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= mix_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mix_go)
        begin
            s1_wins_reg     <= sel.sprite_wins;
            s1_mode_reg     <= cfg_reg.color_mode;
            s1_mono_rgb_reg <= sel.mono_rgb;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_rgb_next   = out_rgb_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
            if (s1_mode_reg)
            begin
                out_rgb_next = pmpc_pkg::rgb555_to_888(s1_wins_reg ? obj_word : bg_word);
            end
            else
            begin
                out_rgb_next = s1_mono_rgb_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rgb_reg <= out_rgb_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rgb_reg;

endmodule

// ===== sv/pmpc_checker.sv =====
// ----------------------------------------------------------------------------
// pmpc_checker
// Port-level checks of the pixel mix and palette unit, bound to the top level.
// ----------------------------------------------------------------------------
module pmpc_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [1:0]                       s_tuser,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [pmpc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    // The input side only stalls when both pipeline slots are full.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with room in the pipeline");

    // A new result comes from a mix item accepted earlier.
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == pmpc_pkg::ACT_MIX), 2))
        else $error("result item without a matching mix item");

endmodule

bind pixel_mix_and_palette_color_unit pmpc_checker u_pmpc_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Pixel mix and palette color unit testbench
// Streams mix items and palette byte writes into the unit under random
// idling on both sides, predicts every RGB result from a behavioral model of
// the priority rules, shade maps and palette RAM, and compares each output
// item against the oldest prediction. Configuration changes only while idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          IDLE_PCT         = 28;
    localparam int          SETTLE_CYCLES    = 8;
    localparam int          LIMIT_CYCLES     = 200000;
    localparam int          RANDOM_PHASES    = 8;
    localparam int          ITEMS_PER_PHASE  = 200;
    localparam int          MAX_REPORTS      = 10;
    localparam logic [1:0]  ACT_NOP          = 2'd3;

    // Shade 3 in the top bits down to shade 0 in the bottom bits.
    localparam bit [95:0]   SHADE_TABLE = {24'h081820, 24'h346856, 24'h88c070, 24'he0f8d0};

    typedef struct packed {
        logic [1:0]       action;
        pmpc_pkg::pix_t   px;
        logic [5:0]       pal_idx;
        logic [7:0]       pal_data;
    } pixel_item_t;

    bit                                 clk;
    logic                               rst_n;
    logic [pmpc_pkg::IN_TDATA_W-1:0]    s_tdata;
    logic [1:0]                         s_tuser;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [pmpc_pkg::OUT_TDATA_W-1:0]   m_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic                               cfg_wr_en;
    logic [pmpc_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [pmpc_pkg::CFG_DATA_W-1:0]    cfg_data;

    pixel_item_t              pending_items[$];
    bit [23:0]                rgb_expected[$];
    pixel_item_t              cur_item;
    pixel_item_t              next_item;
    bit                       item_taken;
    bit                       hold_sender;
    bit                       steady_flow;
    int                       cycle_count;
    int                       error_count;

    // Shadow copy of the unit's registers and palette RAM.
    bit                       sh_color_mode;
    bit                       sh_bg_enable;
    bit [7:0]                 sh_bg_map;
    bit [7:0]                 sh_obj_map0;
    bit [7:0]                 sh_obj_map1;
    bit [7:0]                 bg_pal_bytes[64];
    bit [7:0]                 obj_pal_bytes[64];

    pixel_mix_and_palette_color_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit [23:0] shade_of(input bit [7:0] map, input bit [1:0] cid);
        bit [1:0] shade;
        shade = map[cid*2 +: 2];
        return SHADE_TABLE[shade*24 +: 24];
    endfunction

    // Little-endian RGB555 word from two palette bytes, each channel widened to 8 bits.
    function automatic bit [23:0] rgb_from_bytes(input bit [7:0] lo, input bit [7:0] hi);
        bit [14:0] w;
        w = {hi[6:0], lo};
        return {w[4:0], w[4:2], w[9:5], w[9:7], w[14:10], w[14:12]};
    endfunction

    task automatic predict_item(input pixel_item_t it);
        bit               sprite_wins;
        bit [23:0]        rgb;
        pmpc_pkg::pix_t   p;
        p = it.px;
        case (it.action)
            pmpc_pkg::ACT_WR_BG:  bg_pal_bytes[it.pal_idx] = it.pal_data;
            pmpc_pkg::ACT_WR_OBJ: obj_pal_bytes[it.pal_idx] = it.pal_data;
            pmpc_pkg::ACT_MIX:
            begin
                if (!p.sprite_present || p.sprite_color_id == 2'd0)
                    sprite_wins = 1'b0;
                else if (!sh_color_mode)
                    sprite_wins = !(p.sprite_behind_bg && sh_bg_enable && p.bg_color_id != 2'd0);
                else if (p.bg_color_id == 2'd0)
                    sprite_wins = 1'b1;
                else
                    sprite_wins = !sh_bg_enable || (!p.sprite_behind_bg && !p.bg_priority);

                if (!sh_color_mode)
                begin
                    if (sprite_wins)
                        rgb = shade_of(p.sprite_palette_num[0] ? sh_obj_map1 : sh_obj_map0,
                                       p.sprite_color_id);
                    else if (!sh_bg_enable)
                        rgb = shade_of(8'h00, p.bg_color_id);
                    else
                        rgb = shade_of(sh_bg_map, p.bg_color_id);
                end
                else if (sprite_wins)
                begin
                    rgb = rgb_from_bytes(
                        obj_pal_bytes[{p.sprite_palette_num, p.sprite_color_id, 1'b0}],
                        obj_pal_bytes[{p.sprite_palette_num, p.sprite_color_id, 1'b1}]);
                end
                else
                begin
                    rgb = rgb_from_bytes(bg_pal_bytes[{p.bg_palette_num, p.bg_color_id, 1'b0}],
                                         bg_pal_bytes[{p.bg_palette_num, p.bg_color_id, 1'b1}]);
                end
                rgb_expected.insert(rgb_expected.size(), rgb);
            end
            default: ;
        endcase
    endtask

    task automatic flag_error(input string what, input bit [23:0] want, input logic [23:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s: expected %06h, got %06h", what, want, got);
    endtask

    // Output check first: a result leaving now belongs to an item taken earlier.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
        else if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (rgb_expected.size() == 0)
                    flag_error("unexpected rgb item", 24'h0, m_tdata);
                else
                begin
                    if (m_tdata !== rgb_expected[0])
                        flag_error("rgb mismatch", rgb_expected[0], m_tdata);
                    rgb_expected.delete(0);
                end
            end
            if (s_tvalid && s_tready)
                predict_item(cur_item);
        end
        item_taken <= rst_n && s_tvalid && s_tready;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
            if (!s_tvalid || item_taken)
            begin
                if (pending_items.size() != 0 && !hold_sender &&
                    (steady_flow || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_item = pending_items[0];
                    pending_items.delete(0);
                    cur_item  <= next_item;
                    s_tdata   <= {5'd0, next_item.pal_data, next_item.pal_idx,
                                  next_item.px.sprite_behind_bg,
                                  next_item.px.sprite_palette_num,
                                  next_item.px.sprite_color_id,
                                  next_item.px.sprite_present,
                                  next_item.px.bg_priority,
                                  next_item.px.bg_palette_num,
                                  next_item.px.bg_color_id};
                    s_tuser   <= next_item.action;
                    s_tvalid  <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic pmpc_pkg::pix_t random_pixel();
        pmpc_pkg::pix_t p;
        p.bg_color_id        = 2'($urandom_range(3));
        p.bg_palette_num     = 3'($urandom_range(7));
        p.bg_priority        = 1'($urandom_range(1));
        p.sprite_present     = 1'($urandom_range(1));
        p.sprite_color_id    = 2'($urandom_range(3));
        p.sprite_palette_num = 3'($urandom_range(7));
        p.sprite_behind_bg   = 1'($urandom_range(1));
        return p;
    endfunction

    function automatic pixel_item_t random_item();
        pixel_item_t it;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            it.action = pmpc_pkg::ACT_MIX;
        else if (roll < 75)
            it.action = pmpc_pkg::ACT_WR_BG;
        else if (roll < 94)
            it.action = pmpc_pkg::ACT_WR_OBJ;
        else
            it.action = ACT_NOP;
        it.px       = random_pixel();
        it.pal_idx  = 6'($urandom_range(63));
        it.pal_data = 8'($urandom_range(255));
        return it;
    endfunction

    task automatic queue_mix(input bit [1:0] bg_cid, input bit [2:0] bg_pal, input bit bg_prio,
                             input bit spr_here, input bit [1:0] spr_cid,
                             input bit [2:0] spr_pal, input bit behind);
        pixel_item_t it;
        it = random_item();
        it.action                = pmpc_pkg::ACT_MIX;
        it.px.bg_color_id        = bg_cid;
        it.px.bg_palette_num     = bg_pal;
        it.px.bg_priority        = bg_prio;
        it.px.sprite_present     = spr_here;
        it.px.sprite_color_id    = spr_cid;
        it.px.sprite_palette_num = spr_pal;
        it.px.sprite_behind_bg   = behind;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic queue_ctl(input logic [1:0] action, input bit [5:0] idx, input bit [7:0] data);
        pixel_item_t it;
        it = random_item();
        it.action   = action;
        it.pal_idx  = idx;
        it.pal_data = data;
        pending_items.insert(pending_items.size(), it);
    endtask

    // A write or an unknown item leaves no result, so let the pipeline settle too.
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || rgb_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pmpc_pkg::CFG_INDEX_W-1:0] idx, input bit [7:0] value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            pmpc_pkg::CFG_COLOR_MODE: sh_color_mode = value[0];
            pmpc_pkg::CFG_BG_ENABLE:  sh_bg_enable  = value[0];
            pmpc_pkg::CFG_BG_MAP:     sh_bg_map     = value;
            pmpc_pkg::CFG_OBJ_MAP0:   sh_obj_map0   = value;
            pmpc_pkg::CFG_OBJ_MAP1:   sh_obj_map1   = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input bit cm, input bit be, input bit [7:0] bgm,
                              input bit [7:0] m0, input bit [7:0] m1);
        wait_idle();
        write_reg(pmpc_pkg::CFG_COLOR_MODE, {7'd0, cm});
        write_reg(pmpc_pkg::CFG_BG_ENABLE, {7'd0, be});
        write_reg(pmpc_pkg::CFG_BG_MAP, bgm);
        write_reg(pmpc_pkg::CFG_OBJ_MAP0, m0);
        write_reg(pmpc_pkg::CFG_OBJ_MAP1, m1);
    endtask

    initial
    begin
        int phase;
        int n;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = pmpc_pkg::ACT_MIX;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = pmpc_pkg::CFG_COLOR_MODE;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: monochrome with the background off.
        queue_mix(2'd3, 3'd7, 1'b1, 1'b0, 2'd3, 3'd7, 1'b1);
        queue_mix(2'd1, 3'd0, 1'b0, 1'b1, 2'd2, 3'd1, 1'b1);
        queue_ctl(ACT_NOP, 6'd63, 8'hFF);

        set_config(1'b0, 1'b1, 8'hE4, 8'h1B, 8'hFF);
        queue_mix(2'd2, 3'd0, 1'b0, 1'b1, 2'd0, 3'd0, 1'b0);
        queue_mix(2'd0, 3'd0, 1'b0, 1'b1, 2'd3, 3'd0, 1'b1);
        queue_mix(2'd1, 3'd0, 1'b0, 1'b1, 2'd2, 3'd1, 1'b1);
        queue_mix(2'd3, 3'd0, 1'b0, 1'b1, 2'd1, 3'd6, 1'b0);
        queue_mix(2'd3, 3'd0, 1'b0, 1'b1, 2'd1, 3'd7, 1'b0);

        set_config(1'b0, 1'b0, 8'hE4, 8'h1B, 8'hFF);
        queue_mix(2'd3, 3'd0, 1'b0, 1'b1, 2'd2, 3'd1, 1'b1);
        queue_mix(2'd2, 3'd0, 1'b0, 1'b0, 2'd2, 3'd0, 1'b0);

        // Color mode: each palette write is read back by the next mix items.
        set_config(1'b1, 1'b1, 8'h00, 8'h00, 8'h00);
        queue_ctl(pmpc_pkg::ACT_WR_BG, 6'd62, 8'hFF);
        queue_ctl(pmpc_pkg::ACT_WR_BG, 6'd63, 8'hFF);
        queue_ctl(pmpc_pkg::ACT_WR_OBJ, 6'd2, 8'hE5);
        queue_ctl(pmpc_pkg::ACT_WR_OBJ, 6'd3, 8'h7C);
        queue_mix(2'd3, 3'd7, 1'b0, 1'b0, 2'd1, 3'd0, 1'b0);
        queue_mix(2'd0, 3'd7, 1'b1, 1'b1, 2'd1, 3'd0, 1'b1);
        queue_mix(2'd3, 3'd7, 1'b1, 1'b1, 2'd1, 3'd0, 1'b0);
        queue_mix(2'd3, 3'd7, 1'b0, 1'b1, 2'd1, 3'd0, 1'b1);
        queue_mix(2'd3, 3'd7, 1'b0, 1'b1, 2'd1, 3'd0, 1'b0);
        queue_ctl(ACT_NOP, 6'd0, 8'h00);

        set_config(1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
        queue_mix(2'd3, 3'd7, 1'b1, 1'b1, 2'd1, 3'd0, 1'b1);
        queue_mix(2'd3, 3'd7, 1'b1, 1'b1, 2'd0, 3'd0, 1'b0);
        queue_ctl(pmpc_pkg::ACT_WR_OBJ, 6'd63, 8'h80);
        queue_ctl(pmpc_pkg::ACT_WR_OBJ, 6'd0, 8'h00);
        queue_mix(2'd0, 3'd0, 1'b0, 1'b1, 2'd3, 3'd7, 1'b0);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_config(1'b0, 1'b1, 8'hE4, 8'h1B, 8'hFF);
                1: set_config(1'b0, 1'b0, 8'h00, 8'hFF, 8'h00);
                2: set_config(1'b1, 1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
                3: set_config(1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF);
                default: set_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                                    8'($urandom_range(255)), 8'($urandom_range(255)),
                                    8'($urandom_range(255)));
            endcase
            steady_flow = (phase == 2);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                pending_items.insert(pending_items.size(), random_item());
            if (phase == 5)
            begin
                // Hold the sender midway until every pending result has drained.
                while (pending_items.size() > ITEMS_PER_PHASE / 2)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (s_tvalid || rgb_expected.size() != 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
